// File: rtl/nts_pkg.sv
package nts_pkg;

  localparam int MAX_DIM         = 256;
  localparam int COORD_FRAC_BITS = 16;

  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = IDX_W + 1;
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int COORD_W     = 24;
  localparam int COLOR_W     = 16;
  localparam int CHAN_W      = 8;
  localparam int TEXEL_W     = 3 * CHAN_W;
  localparam int INDEX_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int MODE_W      = 2;

  // Width of coord * (size - 1) before rounding.
  localparam int P_W = COORD_FRAC_BITS + 1 + IDX_W;

  // Colour times texel plus rounding constant.
  localparam int MIX_W = COLOR_W + CHAN_W;

  // floor(x / 255) = (x * ceil(2^32 / 255)) >> 32, exact for x below 2^24.
  localparam int                      DIV_M_W     = 25;
  localparam int                      DIV_SHIFT   = 32;
  localparam logic [DIV_M_W-1:0]      DIV255_MUL  = 25'd16843010;
  localparam logic [MIX_W-1:0]        ROUND_255   = MIX_W'(127);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [MODE_W-1:0] WRAP_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] WRAP_REPEAT = 2'd1;
  localparam logic [MODE_W-1:0] WRAP_CLAMP  = 2'd2;

  localparam logic [MODE_W-1:0] ENV_PASS     = 2'd0;
  localparam logic [MODE_W-1:0] ENV_MODULATE = 2'd1;
  localparam logic [MODE_W-1:0] ENV_REPLACE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_S     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_T     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 3'd4;

  typedef struct packed {
    logic                       action;
    logic [INDEX_W-1:0]         texel_index;
    logic [CHAN_W-1:0]          texel_red;
    logic [CHAN_W-1:0]          texel_green;
    logic [CHAN_W-1:0]          texel_blue;
    logic signed [COORD_W-1:0]  coord_s;
    logic signed [COORD_W-1:0]  coord_t;
    logic [COLOR_W-1:0]         color_red;
    logic [COLOR_W-1:0]         color_green;
    logic [COLOR_W-1:0]         color_blue;
  } nts_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               skipped;
  } nts_rsp_t;

  typedef struct packed {
    logic [MODE_W-1:0] wrap_s_mode;
    logic [MODE_W-1:0] wrap_t_mode;
    logic [MODE_W-1:0] env_mode;
    logic [DIM_W-1:0]  tex_width;
    logic [DIM_W-1:0]  tex_height;
  } nts_cfg_t;

  typedef struct packed {
    logic               is_write;
    logic               skip;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] texel;
    logic [COLOR_W-1:0] col_r;
    logic [COLOR_W-1:0] col_g;
    logic [COLOR_W-1:0] col_b;
  } nts_entry_t;

endpackage

// File: rtl/nts_ram.sv
module nts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/nts_front.sv
module nts_front (
  input  logic                clk,
  input  logic                rst,
  input  nts_pkg::nts_cfg_t   cfg,
  input  logic                req_valid,
  output logic                req_ready,
  input  nts_pkg::nts_req_t   req,
  output logic                push,
  output nts_pkg::nts_entry_t push_entry,
  input  logic                full
);

  function automatic logic [nts_pkg::COORD_FRAC_BITS:0] wrap_coord(
    input logic [nts_pkg::COORD_W-2:0] c,
    input logic [nts_pkg::MODE_W-1:0]  mode
  );
    logic [nts_pkg::COORD_W-2:0]         one;
    logic [nts_pkg::COORD_FRAC_BITS:0]   r;
    one = (nts_pkg::COORD_W-1)'(1) << nts_pkg::COORD_FRAC_BITS;
    if (mode == nts_pkg::WRAP_REPEAT) begin
      r = {1'b0, c[nts_pkg::COORD_FRAC_BITS-1:0]};
    end else if (c > one) begin
      r = one[nts_pkg::COORD_FRAC_BITS:0];
    end else begin
      r = c[nts_pkg::COORD_FRAC_BITS:0];
    end
    return r;
  endfunction

  function automatic logic [nts_pkg::DIM_W-1:0] limit_size(
    input logic [nts_pkg::DIM_W-1:0] size
  );
    logic [nts_pkg::DIM_W-1:0] r;
    if (size == '0) begin
      r = nts_pkg::DIM_W'(1);
    end else if (size > nts_pkg::DIM_W'(nts_pkg::MAX_DIM)) begin
      r = nts_pkg::DIM_W'(nts_pkg::MAX_DIM);
    end else begin
      r = size;
    end
    return r;
  endfunction

  logic                              adv;
  logic [nts_pkg::DIM_W-1:0]         w_lim;
  logic [nts_pkg::DIM_W-1:0]         h_lim;
  logic [nts_pkg::DIM_W-1:0]         w_m1;
  logic [nts_pkg::DIM_W-1:0]         h_m1;
  logic [nts_pkg::COORD_FRAC_BITS:0] cs_wrap;
  logic [nts_pkg::COORD_FRAC_BITS:0] ct_wrap;
  logic [nts_pkg::P_W-1:0]           ps_next;
  logic [nts_pkg::P_W-1:0]           pt_next;
  nts_pkg::nts_entry_t               e1_next;

  logic                              f1_valid;
  nts_pkg::nts_entry_t               f1_entry;
  logic [nts_pkg::P_W-1:0]           f1_ps;
  logic [nts_pkg::P_W-1:0]           f1_pt;

  logic [nts_pkg::P_W-1:0]           sum_s;
  logic [nts_pkg::P_W-1:0]           sum_t;
  logic [nts_pkg::IDX_W-1:0]         idx_s;
  logic [nts_pkg::IDX_W-1:0]         idx_t;
  logic [2*nts_pkg::IDX_W:0]         row_base;
  nts_pkg::nts_entry_t               e2_next;

  logic                              f2_valid;
  nts_pkg::nts_entry_t               f2_entry;

  // The pipeline only holds when its last stage cannot enter the queue.
  assign adv        = !(f2_valid && full);
  assign req_ready  = adv;
  assign push       = f2_valid && !full;
  assign push_entry = f2_entry;

  always_comb begin
    w_lim   = limit_size(cfg.tex_width);
    h_lim   = limit_size(cfg.tex_height);
    w_m1    = w_lim - nts_pkg::DIM_W'(1);
    h_m1    = h_lim - nts_pkg::DIM_W'(1);
    cs_wrap = wrap_coord(req.coord_s[nts_pkg::COORD_W-2:0], cfg.wrap_s_mode);
    ct_wrap = wrap_coord(req.coord_t[nts_pkg::COORD_W-2:0], cfg.wrap_t_mode);
    ps_next = nts_pkg::P_W'(cs_wrap) * nts_pkg::P_W'(w_m1[nts_pkg::IDX_W-1:0]);
    pt_next = nts_pkg::P_W'(ct_wrap) * nts_pkg::P_W'(h_m1[nts_pkg::IDX_W-1:0]);

    e1_next       = '0;
    e1_next.col_r = req.color_red;
    e1_next.col_g = req.color_green;
    e1_next.col_b = req.color_blue;
    if (req.action == nts_pkg::ACT_WRITE) begin
      e1_next.is_write = 1'b1;
      e1_next.addr     = req.texel_index[nts_pkg::ADDR_W-1:0];
      e1_next.texel    = {req.texel_red, req.texel_green, req.texel_blue};
    end else begin
      e1_next.skip = req.coord_s[nts_pkg::COORD_W-1] | req.coord_t[nts_pkg::COORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_entry <= e1_next;
      f1_ps    <= ps_next;
      f1_pt    <= pt_next;
    end
  end

  always_comb begin
    sum_s    = f1_ps + (nts_pkg::P_W'(1) << (nts_pkg::COORD_FRAC_BITS - 1));
    sum_t    = f1_pt + (nts_pkg::P_W'(1) << (nts_pkg::COORD_FRAC_BITS - 1));
    idx_s    = sum_s[nts_pkg::COORD_FRAC_BITS +: nts_pkg::IDX_W];
    idx_t    = sum_t[nts_pkg::COORD_FRAC_BITS +: nts_pkg::IDX_W];
    row_base = (2*nts_pkg::IDX_W+1)'(idx_t) * (2*nts_pkg::IDX_W+1)'(w_lim);
    e2_next  = f1_entry;
    if (!f1_entry.is_write && !f1_entry.skip) begin
      e2_next.addr = nts_pkg::ADDR_W'(idx_s) + row_base[nts_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (adv) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_entry <= e2_next;
    end
  end

endmodule

// File: rtl/nts_fifo.sv
module nts_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  nts_pkg::nts_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output nts_pkg::nts_entry_t head
);

  nts_pkg::nts_entry_t            slots [nts_pkg::FIFO_DEPTH];
  logic [nts_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [nts_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [nts_pkg::FIFO_AW:0]      count;

  assign full  = (count == (nts_pkg::FIFO_AW+1)'(nts_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + nts_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + nts_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (nts_pkg::FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (nts_pkg::FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: rtl/nts_back.sv
module nts_back (
  input  logic                clk,
  input  logic                rst,
  input  nts_pkg::nts_cfg_t   cfg,
  input  logic                empty,
  input  nts_pkg::nts_entry_t head,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output nts_pkg::nts_rsp_t   rsp
);

  logic                          adv;
  logic [nts_pkg::TEXEL_W-1:0]   texel;

  logic                          a_valid;
  logic                          a_skip;
  logic [nts_pkg::COLOR_W-1:0]   a_col [3];

  logic [nts_pkg::CHAN_W-1:0]    tex_ch [3];
  logic [nts_pkg::MIX_W-1:0]     x_next [3];

  logic                          b_valid;
  logic                          b_skip;
  logic [nts_pkg::COLOR_W-1:0]   b_col [3];
  logic [nts_pkg::MIX_W-1:0]     b_x [3];

  logic [nts_pkg::MIX_W+nts_pkg::DIV_M_W-1:0] quot_prod [3];
  logic [nts_pkg::COLOR_W-1:0]   res [3];
  nts_pkg::nts_rsp_t             rsp_next;

  // Every stage moves together; the RAM read data holds while stalled.
  assign adv = !rsp_valid || rsp_ready;
  assign pop = adv && !empty;

  nts_ram #(
    .WIDTH (nts_pkg::TEXEL_W),
    .DEPTH (nts_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (pop && head.is_write),
    .waddr (head.addr),
    .wdata (head.texel),
    .re    (adv),
    .raddr (head.addr),
    .rdata (texel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pop && !head.is_write;
      b_valid <= a_valid;
    end
  end

  always_comb begin
    tex_ch[0] = texel[2*nts_pkg::CHAN_W +: nts_pkg::CHAN_W];
    tex_ch[1] = texel[nts_pkg::CHAN_W +: nts_pkg::CHAN_W];
    tex_ch[2] = texel[0 +: nts_pkg::CHAN_W];
    for (int i = 0; i < 3; i++) begin
      if (cfg.env_mode == nts_pkg::ENV_REPLACE) begin
        x_next[i] = (nts_pkg::MIX_W'(tex_ch[i]) << 12) + nts_pkg::ROUND_255;
      end else begin
        x_next[i] = nts_pkg::MIX_W'(a_col[i]) * nts_pkg::MIX_W'(tex_ch[i])
                    + nts_pkg::ROUND_255;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_skip   <= head.skip;
      a_col[0] <= head.col_r;
      a_col[1] <= head.col_g;
      a_col[2] <= head.col_b;
      b_skip   <= a_skip;
      for (int i = 0; i < 3; i++) begin
        b_col[i] <= a_col[i];
        b_x[i]   <= x_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot_prod[i] = (nts_pkg::MIX_W+nts_pkg::DIV_M_W)'(b_x[i])
                     * (nts_pkg::MIX_W+nts_pkg::DIV_M_W)'(nts_pkg::DIV255_MUL);
      if (b_skip) begin
        res[i] = b_col[i];
      end else begin
        case (cfg.env_mode) inside
          nts_pkg::ENV_MODULATE,
          nts_pkg::ENV_REPLACE: res[i] = quot_prod[i][nts_pkg::DIV_SHIFT +: nts_pkg::COLOR_W];
          default:              res[i] = b_col[i];
        endcase
      end
    end
    rsp_next.out_red   = res[0];
    rsp_next.out_green = res[1];
    rsp_next.out_blue  = res[2];
    rsp_next.skipped   = b_skip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: rtl/nearest_texture_sampler_top.sv
// Channel   Signals                                   Beat carries
// req       req_valid, req_ready, req                 texel write or sample
// rsp       rsp_valid, rsp_ready, rsp                 shaded colour and skip flag
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data one register write
//
// One item is accepted per cycle while req_ready is high; a sample result passes through
// two front stages, the queue, the texel RAM read and two combine stages before it is
// presented, the first front stage being loaded at the accepting edge.
// Texel writes update the single-port-write store in order with reads, so a sample
// always sees every write that was accepted before it. Reset clears control state only;
// datapath registers and texel contents are undefined until written.
// A four-entry queue separates the front from the back, so an output stall reaches
// req_ready only once the queue has filled.
module nearest_texture_sampler_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  nts_pkg::nts_req_t               req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output nts_pkg::nts_rsp_t               rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nts_pkg::DIM_W-1:0]       cfg_data
);

  nts_pkg::nts_cfg_t   cfg;
  logic                push;
  nts_pkg::nts_entry_t push_entry;
  logic                full;
  logic                pop;
  logic                empty;
  nts_pkg::nts_entry_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_s_mode <= nts_pkg::WRAP_NONE;
      cfg.wrap_t_mode <= nts_pkg::WRAP_NONE;
      cfg.env_mode    <= nts_pkg::ENV_PASS;
      cfg.tex_width   <= nts_pkg::DIM_W'(nts_pkg::MAX_DIM);
      cfg.tex_height  <= nts_pkg::DIM_W'(nts_pkg::MAX_DIM);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nts_pkg::CFG_WRAP_S:     cfg.wrap_s_mode <= cfg_data[nts_pkg::MODE_W-1:0];
        nts_pkg::CFG_WRAP_T:     cfg.wrap_t_mode <= cfg_data[nts_pkg::MODE_W-1:0];
        nts_pkg::CFG_ENV:        cfg.env_mode    <= cfg_data[nts_pkg::MODE_W-1:0];
        nts_pkg::CFG_TEX_WIDTH:  cfg.tex_width   <= cfg_data;
        nts_pkg::CFG_TEX_HEIGHT: cfg.tex_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  nts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  nts_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  nts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: tb/nearest_texture_sampler_top_tb.sv
module nearest_texture_sampler_top_tb;
  import nts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_ITEMS    = 150;

  localparam longint unsigned COORD_ONE  = 64'd1 << COORD_FRAC_BITS;
  localparam longint unsigned COORD_HALF = COORD_ONE >> 1;

  // The fourth code of each mode register has no name in the package.
  localparam logic [MODE_W-1:0] WRAP_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] ENV_SPARE  = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  nts_req_t             req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  nts_rsp_t             rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;

  nts_cfg_t           tex_cfg;
  logic [TEXEL_W-1:0] texel_mem   [STORE_DEPTH];
  bit                 texel_known [STORE_DEPTH];
  nts_rsp_t           expected_colors [$];
  nts_rsp_t           oldest;
  int unsigned        error_count  = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        idle_pct     = 20;
  int unsigned        stall_pct    = 20;
  int unsigned        stall_left   = 0;

  nearest_texture_sampler_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Texture arithmetic.

  function automatic int unsigned fit_size(logic [DIM_W-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_DIM) return MAX_DIM;
    return 32'(size);
  endfunction

  function automatic int unsigned wrap_index(logic [COORD_W-1:0] coord,
                                             logic [MODE_W-1:0] mode, int unsigned size);
    longint unsigned pos;
    pos = 64'(coord);
    if (mode == WRAP_REPEAT) pos = pos % COORD_ONE;
    else if (pos > COORD_ONE) pos = COORD_ONE;
    return 32'((pos * 64'(size - 1) + COORD_HALF) >> COORD_FRAC_BITS);
  endfunction

  function automatic int unsigned texel_addr(nts_req_t item);
    int unsigned w, s, t;
    w = fit_size(tex_cfg.tex_width);
    s = wrap_index(item.coord_s, tex_cfg.wrap_s_mode, w);
    t = wrap_index(item.coord_t, tex_cfg.wrap_t_mode, fit_size(tex_cfg.tex_height));
    return (s + t * w) % STORE_DEPTH;
  endfunction

  function automatic logic [COLOR_W-1:0] mix_channel(logic [COLOR_W-1:0] colour,
                                                     logic [CHAN_W-1:0] texel);
    longint unsigned c, x;
    c = 64'(colour);
    x = 64'(texel);
    case (tex_cfg.env_mode)
      ENV_MODULATE: return COLOR_W'((c * x + 127) / 255);
      ENV_REPLACE:  return COLOR_W'((x * 4096 + 127) / 255);
      default:      return colour;
    endcase
  endfunction

  function automatic nts_rsp_t shade_sample(nts_req_t item);
    nts_rsp_t           res;
    logic [TEXEL_W-1:0] texel;
    res.out_red   = item.color_red;
    res.out_green = item.color_green;
    res.out_blue  = item.color_blue;
    res.skipped   = 1'b1;
    if (item.coord_s[COORD_W-1] || item.coord_t[COORD_W-1]) return res;
    texel = texel_mem[texel_addr(item)];
    res.out_red   = mix_channel(item.color_red, texel[3*CHAN_W-1:2*CHAN_W]);
    res.out_green = mix_channel(item.color_green, texel[2*CHAN_W-1:CHAN_W]);
    res.out_blue  = mix_channel(item.color_blue, texel[CHAN_W-1:0]);
    res.skipped   = 1'b0;
    return res;
  endfunction

  // Item builders. Fields that the action does not use carry random noise.

  function automatic nts_req_t random_req();
    nts_req_t r;
    r.action      = 1'($urandom);
    r.texel_index = INDEX_W'($urandom);
    r.texel_red   = CHAN_W'($urandom);
    r.texel_green = CHAN_W'($urandom);
    r.texel_blue  = CHAN_W'($urandom);
    r.coord_s     = COORD_W'($urandom);
    r.coord_t     = COORD_W'($urandom);
    r.color_red   = COLOR_W'($urandom);
    r.color_green = COLOR_W'($urandom);
    r.color_blue  = COLOR_W'($urandom);
    return r;
  endfunction

  function automatic nts_req_t texel_write(logic [INDEX_W-1:0] index,
                                           logic [TEXEL_W-1:0] texel);
    nts_req_t r;
    r = random_req();
    r.action      = ACT_WRITE;
    r.texel_index = index;
    {r.texel_red, r.texel_green, r.texel_blue} = texel;
    return r;
  endfunction

  function automatic nts_req_t make_sample(logic [COORD_W-1:0] s, logic [COORD_W-1:0] t,
                                           logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                                           logic [COLOR_W-1:0] blue);
    nts_req_t r;
    r = random_req();
    r.action      = ACT_SAMPLE;
    r.coord_s     = s;
    r.coord_t     = t;
    r.color_red   = red;
    r.color_green = green;
    r.color_blue  = blue;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 5))
      0, 1:    return COORD_W'($urandom_range(0, 32'h10000));
      2:       return COORD_W'({$urandom_range(0, 3), 16'h8000});
      3:       return COORD_W'($urandom_range(0, 32'h7FFFFF));
      4:       return $urandom_range(0, 1) ? COORD_W'(32'h10000) : '0;
      default: return COORD_W'($urandom_range(0, 32'h2FFFF));
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] random_color();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_size();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return DIM_W'($urandom_range(1, 8));
      8, 9, 10, 11:           return DIM_W'($urandom_range(9, 64));
      12, 13:                 return DIM_W'($urandom_range(65, 256));
      14, 15, 16:             return DIM_W'($urandom_range(257, 511));
      17:                     return '0;
      18:                     return DIM_W'(1);
      default:                return DIM_W'(MAX_DIM);
    endcase
  endfunction

  function automatic int unsigned random_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Mode registers only look at their low bits, so the rest carries noise.
  function automatic logic [DIM_W-1:0] mode_word(logic [MODE_W-1:0] mode);
    logic [DIM_W-1:0] pad;
    pad = DIM_W'($urandom);
    return {pad[DIM_W-1:MODE_W], mode};
  endfunction

  // Channel drivers.

  task automatic send_item(input nts_req_t item);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (item.action == ACT_WRITE) begin
      texel_mem[item.texel_index]   = {item.texel_red, item.texel_green, item.texel_blue};
      texel_known[item.texel_index] = 1'b1;
    end else begin
      expected_colors.push_back(shade_sample(item));
    end
  endtask

  // A texel must be written before any sample reads it.
  task automatic send_sample(input nts_req_t item);
    int unsigned addr;
    if (!item.coord_s[COORD_W-1] && !item.coord_t[COORD_W-1]) begin
      addr = texel_addr(item);
      if (!texel_known[addr]) send_item(texel_write(INDEX_W'(addr), TEXEL_W'($urandom)));
    end
    send_item(item);
  endtask

  task automatic wait_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (expected_colors.size() != 0);
  endtask

  // Write beats produce no result, so give the pipeline time to empty as well.
  task automatic settle_block();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_WRAP_S:     tex_cfg.wrap_s_mode = value[MODE_W-1:0];
      CFG_WRAP_T:     tex_cfg.wrap_t_mode = value[MODE_W-1:0];
      CFG_ENV:        tex_cfg.env_mode    = value[MODE_W-1:0];
      CFG_TEX_WIDTH:  tex_cfg.tex_width   = value;
      CFG_TEX_HEIGHT: tex_cfg.tex_height  = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(input nts_cfg_t c);
    write_reg(CFG_WRAP_S, mode_word(c.wrap_s_mode));
    write_reg(CFG_WRAP_T, mode_word(c.wrap_t_mode));
    write_reg(CFG_ENV, mode_word(c.env_mode));
    write_reg(CFG_TEX_WIDTH, c.tex_width);
    write_reg(CFG_TEX_HEIGHT, c.tex_height);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned roll;
    int unsigned span;
    nts_req_t    item;
    roll = $urandom_range(0, 99);
    span = fit_size(tex_cfg.tex_width) * fit_size(tex_cfg.tex_height);
    if (roll < 25) begin
      if ($urandom_range(0, 1) != 0)
        send_item(texel_write(INDEX_W'($urandom_range(0, span - 1)), TEXEL_W'($urandom)));
      else
        send_item(texel_write(INDEX_W'($urandom), TEXEL_W'($urandom)));
    end else begin
      item = make_sample(random_coord(), random_coord(), random_color(), random_color(),
                         random_color());
      if (roll < 31) begin
        case ($urandom_range(0, 2))
          0:       item.coord_s[COORD_W-1] = 1'b1;
          1:       item.coord_t[COORD_W-1] = 1'b1;
          default: begin
            item.coord_s[COORD_W-1] = 1'b1;
            item.coord_t[COORD_W-1] = 1'b1;
          end
        endcase
      end
      send_sample(item);
    end
  endtask

  // Tests.

  task automatic test_skip_cases();
    send_item(texel_write('0, 24'hFF0080));
    send_sample(make_sample('0, '0, '1, '0, 16'h8000));
    send_sample(make_sample(24'hFFFFFF, '0, 16'h1234, '1, '0));
    send_sample(make_sample('0, 24'h800000, '0, 16'hABCD, '1));
    send_sample(make_sample(24'h800000, 24'h800000, '1, '1, '1));
    send_sample(make_sample(24'h7FFFFF, 24'h7FFFFF, '1, '1, '1));
  endtask

  task automatic test_env_modes();
    logic [MODE_W-1:0] envs [4];
    envs = '{ENV_PASS, ENV_MODULATE, ENV_REPLACE, ENV_SPARE};
    foreach (envs[k]) begin
      settle_block();
      apply_config('{WRAP_CLAMP, WRAP_CLAMP, envs[k], DIM_W'(2), DIM_W'(2)});
      if (k == 0) begin
        send_item(texel_write('0, 24'hFF007F));
        send_item(texel_write(INDEX_W'(3), 24'h00FF80));
      end
      send_sample(make_sample('0, '0, '1, 16'h1000, 16'h0001));
      send_sample(make_sample(24'h010000, 24'h010000, '1, '0, 16'h8001));
    end
  endtask

  task automatic test_wrap_and_size();
    settle_block();
    apply_config('{WRAP_REPEAT, WRAP_SPARE, ENV_REPLACE, DIM_W'(511), DIM_W'(0)});
    send_sample(make_sample(24'h018000, 24'h7FFFFF, random_color(), random_color(), '1));
    send_sample(make_sample(24'h00FFFF, 24'h000003, '0, random_color(), random_color()));
    send_sample(make_sample(24'h7FFFFF, '0, random_color(), '1, random_color()));
    settle_block();
    apply_config('{WRAP_CLAMP, WRAP_REPEAT, ENV_MODULATE, DIM_W'(2), DIM_W'(257)});
    send_sample(make_sample(24'h008000, 24'h028000, '1, '1, '1));
    send_sample(make_sample(24'h007FFF, 24'h010000, random_color(), '1, random_color()));
    settle_block();
    apply_config('{WRAP_NONE, WRAP_NONE, ENV_MODULATE, DIM_W'(1), DIM_W'(1)});
    send_sample(make_sample(24'h7FFFFF, 24'h008000, '1, '1, '1));
  endtask

  task automatic test_random_traffic();
    nts_cfg_t c;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      c.wrap_s_mode = MODE_W'($urandom_range(0, 3));
      c.wrap_t_mode = MODE_W'($urandom_range(0, 3));
      c.env_mode    = MODE_W'($urandom_range(0, 3));
      c.tex_width   = random_size();
      c.tex_height  = random_size();
      apply_config(c);
      idle_pct  = random_idle();
      stall_pct = random_idle();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the sender once mid-phase until the result queue runs dry.
        if (phase == RANDOM_PHASES / 2 && n == PHASE_ITEMS / 2) wait_results();
        send_random_item();
      end
    end
  endtask

  task automatic test_full_rate();
    settle_block();
    idle_pct  = 0;
    stall_pct = 0;
    apply_config('{WRAP_REPEAT, WRAP_REPEAT, ENV_MODULATE, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM)});
    for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
  endtask

  // Result side.

  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 4);
    rsp_ready <= (stall_left == 0);
  end

  task automatic flag_mismatch(input string what, input logic [COLOR_W-1:0] want,
                               input logic [COLOR_W-1:0] got);
    error_count++;
    if (error_count <= 10) $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_colors.size() == 0) begin
        flag_mismatch("unexpected result, out_red", 'x, rsp.out_red);
      end else begin
        oldest = expected_colors.pop_front();
        if (rsp.out_red !== oldest.out_red)
          flag_mismatch("out_red", oldest.out_red, rsp.out_red);
        if (rsp.out_green !== oldest.out_green)
          flag_mismatch("out_green", oldest.out_green, rsp.out_green);
        if (rsp.out_blue !== oldest.out_blue)
          flag_mismatch("out_blue", oldest.out_blue, rsp.out_blue);
        if (rsp.skipped !== oldest.skipped)
          flag_mismatch("skipped", COLOR_W'(oldest.skipped), COLOR_W'(rsp.skipped));
      end
    end
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    tex_cfg = '{WRAP_NONE, WRAP_NONE, ENV_PASS, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM)};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_skip_cases();
    test_env_modes();
    test_wrap_and_size();
    test_random_traffic();
    test_full_rate();
    settle_block();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
